### rtl/matrix_chain_order_cost_macros.svh
// Assertion helpers for the block that checks itself.
`ifndef MATRIX_CHAIN_ORDER_COST_MACROS_SVH
`define MATRIX_CHAIN_ORDER_COST_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define MCOC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define MCOC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mcoc_pkg.sv
package mcoc_pkg;

  localparam int unsigned DIM_W  = 12;
  localparam int unsigned COST_W = 48;
  localparam int unsigned STAT_W = 2;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LONG  = 2'd1,
    ST_TOO_SHORT = 2'd2,
    ST_SATURATED = 2'd3
  } status_e;

  typedef struct packed {
    logic [DIM_W-1:0] dimension;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [COST_W-1:0] min_cost;
    logic [STAT_W-1:0] status;
  } out_item_t;

  // Sequencer to datapath controls
  typedef struct packed {
    logic dim_we;    // store an incoming dimension
    logic lat_pim1;  // capture p[i-1] from the dimension read port
    logic lat_pj;    // capture p[j] from the dimension read port
    logic step;      // issue one split k of the current sub-chain
    logic first;     // split k == i: left cost is the diagonal
    logic zero_b;    // split k+1 == j: right cost is the diagonal
    logic wr_best;   // write the best cost back to the table
  } ctrl_t;

  // Datapath to sequencer status
  typedef struct packed {
    logic              busy;
    logic [COST_W-1:0] best;
  } dp_stat_t;

  // Add two costs, clamping at the maximum
  function automatic logic [COST_W-1:0] sat_add(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, COST_MAX}) ? COST_MAX : s[COST_W-1:0];
  endfunction

endpackage

### rtl/mcoc_stream_if.sv
interface mcoc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/matrix_chain_order_cost.sv
// Matrix chain order cost. Dimensions stream in on in_i, one per transfer, the final one
// marked by last. After the last dimension the block fills a table of sub-chain costs,
// row by row from the last start index down to the first and each row from short
// sub-chains to long ones, and then offers one result on out_o: the minimum scalar
// multiplication count (clamped at 2^48-1) and a status. For each sub-chain (i, j) it
// fetches the outer dimensions, issues the splits back to back through a single
// multiply/add pipeline fed by the two read ports of the cost table, waits for the
// pipeline to drain and writes the best cost back. A chain that is too long, too short
// or only two dimensions answers without running the search. The cost table is
// 2^(2*ceil(log2 MAX_DIMENSIONS)) entries of 48 bits and needs no clearing pass after reset.
// Input is taken again once the result has been placed in the output register.
`include "matrix_chain_order_cost_macros.svh"

module matrix_chain_order_cost #(
  parameter int unsigned MAX_DIMENSIONS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mcoc_stream_if.sink   in_i,
  mcoc_stream_if.source out_o
);

  localparam int unsigned IW = $clog2(MAX_DIMENSIONS);
  localparam int unsigned AW = 2 * IW;

  mcoc_pkg::ctrl_t            ctrl;
  mcoc_pkg::dp_stat_t         stat;
  logic [IW-1:0]              dim_waddr;
  logic [IW-1:0]              dim_raddr;
  logic [mcoc_pkg::DIM_W-1:0] dim_wdata;
  logic [AW-1:0]              cost_raddr_a;
  logic [AW-1:0]              cost_raddr_b;
  logic [AW-1:0]              cost_waddr;
  logic                       out_sat;
  logic                       out_rejected;

  mcoc_seq #(
    .MAX_DIMENSIONS (MAX_DIMENSIONS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .out_o          (out_o),
    .stat_i         (stat),
    .ctrl_o         (ctrl),
    .dim_waddr_o    (dim_waddr),
    .dim_wdata_o    (dim_wdata),
    .dim_raddr_o    (dim_raddr),
    .cost_raddr_a_o (cost_raddr_a),
    .cost_raddr_b_o (cost_raddr_b),
    .cost_waddr_o   (cost_waddr)
  );

  mcoc_dp #(
    .MAX_DIMENSIONS (MAX_DIMENSIONS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .dim_waddr_i    (dim_waddr),
    .dim_wdata_i    (dim_wdata),
    .dim_raddr_i    (dim_raddr),
    .cost_raddr_a_i (cost_raddr_a),
    .cost_raddr_b_i (cost_raddr_b),
    .cost_waddr_i   (cost_waddr),
    .stat_o         (stat)
  );

  // Classify the offered result
  assign out_sat      = out_o.valid && (out_o.data.status == mcoc_pkg::ST_SATURATED);
  assign out_rejected = out_o.valid && ((out_o.data.status == mcoc_pkg::ST_TOO_LONG) ||
                                        (out_o.data.status == mcoc_pkg::ST_TOO_SHORT));

  // Write-back only once every split of the sub-chain has been folded in
  `MCOC_ASSERT_IMP(a_wb_after_drain, ctrl.wr_best, !stat.busy, "cost write-back in flight")
  // No dimension transfer while the split search runs
  `MCOC_ASSERT_IMP(a_no_load_in_search, ctrl.step, !in_i.ready, "input open during search")
  // An issued split must show up in the pipeline
  `MCOC_ASSERT_NXT(a_step_enters_pipe, ctrl.step, stat.busy, "issued split lost")
  // A saturated result carries the clamped cost
  `MCOC_ASSERT_IMP(a_sat_cost, out_sat, out_o.data.min_cost == mcoc_pkg::COST_MAX, "bad sat cost")
  // A rejected chain reports no cost
  `MCOC_ASSERT_IMP(a_reject_zero, out_rejected, out_o.data.min_cost == '0, "rejected with cost")

endmodule

### rtl/mcoc_seq.sv
module mcoc_seq #(
  parameter int unsigned MAX_DIMENSIONS = 32,
  localparam int unsigned IW = $clog2(MAX_DIMENSIONS),
  localparam int unsigned CW = $clog2(MAX_DIMENSIONS + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  mcoc_stream_if.sink                in_i,
  mcoc_stream_if.source              out_o,
  input  mcoc_pkg::dp_stat_t         stat_i,
  output mcoc_pkg::ctrl_t            ctrl_o,
  output logic [IW-1:0]              dim_waddr_o,
  output logic [mcoc_pkg::DIM_W-1:0] dim_wdata_o,
  output logic [IW-1:0]              dim_raddr_o,
  output logic [2*IW-1:0]            cost_raddr_a_o,
  output logic [2*IW-1:0]            cost_raddr_b_o,
  output logic [2*IW-1:0]            cost_waddr_o
);

  typedef enum logic [6:0] {
    S_LOAD   = 7'b0000001,
    S_SETUP0 = 7'b0000010,
    S_SETUP1 = 7'b0000100,
    S_SETUP2 = 7'b0001000,
    S_STEP   = 7'b0010000,
    S_DRAIN  = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic                overlong_q, overlong_d;
  logic                calc_q, calc_d;
  mcoc_pkg::status_e   status_q, status_d;
  logic [IW-1:0]       i_q, i_d, j_q, j_d, k_q, k_d;
  logic                out_valid_q, out_valid_d;
  mcoc_pkg::out_item_t res_q, res_d;

  logic                accept;
  logic                room;
  logic [CW-1:0]       count_nx;
  logic                ovl_nx;
  logic                is_first;
  logic                is_last_k;
  logic                is_last_j;
  logic                out_free;
  logic [IW-1:0]       k_inc;

  assign accept    = in_i.valid & in_i.ready;
  assign room      = count_q < CW'(MAX_DIMENSIONS);
  assign count_nx  = room ? count_q + CW'(1) : count_q;
  assign ovl_nx    = overlong_q | ~room;
  assign k_inc     = k_q + IW'(1);
  assign is_first  = (k_q == i_q);
  assign is_last_k = ((IW+1)'(k_q) + (IW+1)'(1)) == (IW+1)'(j_q);
  assign is_last_j = CW'(j_q) == (count_q - CW'(1));
  assign out_free  = ~out_valid_q | out_o.ready;

  // Handshake and memory addressing
  assign in_i.ready     = (state_q == S_LOAD);
  assign out_o.valid    = out_valid_q;
  assign out_o.data     = res_q;
  assign dim_waddr_o    = count_q[IW-1:0];
  assign dim_wdata_o    = in_i.data.dimension;
  assign cost_raddr_a_o = {i_q, k_q};
  assign cost_raddr_b_o = {k_inc, j_q};
  assign cost_waddr_o   = {i_q, j_q};

  always_comb begin
    unique case (state_q)
      S_SETUP0: dim_raddr_o = i_q - IW'(1);
      S_SETUP1: dim_raddr_o = j_q;
      default:  dim_raddr_o = k_q;
    endcase
  end

  // Sequence loading, the split search and the result
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    overlong_d  = overlong_q;
    calc_d      = calc_q;
    status_d    = status_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    res_d       = res_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    ctrl_o      = '0;

    unique case (state_q)
      S_LOAD: begin
        if (accept) begin
          ctrl_o.dim_we = room;
          count_d       = count_nx;
          overlong_d    = ovl_nx;
          if (in_i.data.last) begin
            calc_d  = 1'b0;
            state_d = S_FIN;
            if (ovl_nx) begin
              status_d = mcoc_pkg::ST_TOO_LONG;
            end else if (count_nx < CW'(2)) begin
              status_d = mcoc_pkg::ST_TOO_SHORT;
            end else if (count_nx == CW'(2)) begin
              status_d = mcoc_pkg::ST_OK;
            end else begin
              calc_d   = 1'b1;
              status_d = mcoc_pkg::ST_OK;
              i_d      = IW'(count_nx - CW'(2));
              j_d      = IW'(count_nx - CW'(1));
              state_d  = S_SETUP0;
            end
          end
        end
      end
      S_SETUP0: state_d = S_SETUP1;
      S_SETUP1: begin
        ctrl_o.lat_pim1 = 1'b1;
        state_d         = S_SETUP2;
      end
      S_SETUP2: begin
        ctrl_o.lat_pj = 1'b1;
        k_d           = i_q;
        state_d       = S_STEP;
      end
      S_STEP: begin
        ctrl_o.step   = 1'b1;
        ctrl_o.first  = is_first;
        ctrl_o.zero_b = is_last_k;
        if (is_last_k) begin
          state_d = S_DRAIN;
        end else begin
          k_d = k_inc;
        end
      end
      S_DRAIN: begin
        // Wait for the last split to leave the pipeline, then write back
        if (!stat_i.busy) begin
          ctrl_o.wr_best = 1'b1;
          if (is_last_j) begin
            if (i_q == IW'(1)) begin
              state_d = S_FIN;
            end else begin
              i_d     = i_q - IW'(1);
              j_d     = i_q;
              state_d = S_SETUP0;
            end
          end else begin
            j_d     = j_q + IW'(1);
            state_d = S_SETUP0;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          if (calc_q) begin
            res_d.min_cost = stat_i.best;
            res_d.status   = (stat_i.best == mcoc_pkg::COST_MAX) ?
                             mcoc_pkg::ST_SATURATED : mcoc_pkg::ST_OK;
          end else begin
            res_d.min_cost = '0;
            res_d.status   = status_q;
          end
          out_valid_d = 1'b1;
          count_d     = '0;
          overlong_d  = 1'b0;
          state_d     = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      overlong_q  <= 1'b0;
      calc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      overlong_q  <= overlong_d;
      calc_q      <= calc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold loop indices and the result payload
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    i_q      <= i_d;
    j_q      <= j_d;
    k_q      <= k_d;
    res_q    <= res_d;
  end

endmodule

### rtl/mcoc_dp.sv
module mcoc_dp #(
  parameter int unsigned MAX_DIMENSIONS = 32,
  localparam int unsigned IW = $clog2(MAX_DIMENSIONS),
  localparam int unsigned AW = 2 * IW,
  localparam int unsigned DEPTH = 2 ** AW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mcoc_pkg::ctrl_t            ctrl_i,
  input  logic [IW-1:0]              dim_waddr_i,
  input  logic [mcoc_pkg::DIM_W-1:0] dim_wdata_i,
  input  logic [IW-1:0]              dim_raddr_i,
  input  logic [AW-1:0]              cost_raddr_a_i,
  input  logic [AW-1:0]              cost_raddr_b_i,
  input  logic [AW-1:0]              cost_waddr_i,
  output mcoc_pkg::dp_stat_t         stat_o
);

  localparam int unsigned DW  = mcoc_pkg::DIM_W;
  localparam int unsigned CSW = mcoc_pkg::COST_W;
  localparam int unsigned P1W = 2 * DW;
  localparam int unsigned P2W = 3 * DW;

  logic [DW-1:0]  dim_mem  [MAX_DIMENSIONS];
  logic [CSW-1:0] cost_mem [DEPTH];

  logic [DW-1:0]  dim_rd_q;
  logic [CSW-1:0] rda_q, rdb_q;
  logic [DW-1:0]  pim1_q, pj_q;

  logic           v1_q, v2_q, v3_q, v4_q, v5_q;
  logic           first1_q, first2_q, first3_q, first4_q, first5_q;
  logic           zb1_q;
  logic [P1W-1:0] m1_q;
  logic [P2W-1:0] prod3_q;
  logic [CSW-1:0] ca2_q, ca3_q;
  logic [CSW-1:0] cb2_q, cb3_q, cb4_q;
  logic [CSW-1:0] s4_q, c5_q, best_q;

  // Dimension store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.dim_we) begin
      dim_mem[dim_waddr_i] <= dim_wdata_i;
    end
    dim_rd_q <= dim_mem[dim_raddr_i];
  end

  // Cost table: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_best) begin
      cost_mem[cost_waddr_i] <= best_q;
    end
    rda_q <= cost_mem[cost_raddr_a_i];
    rdb_q <= cost_mem[cost_raddr_b_i];
  end

  // Capture the outer dimensions of the current sub-chain
  always_ff @(posedge clk_i) begin
    if (ctrl_i.lat_pim1) begin
      pim1_q <= dim_rd_q;
    end
    if (ctrl_i.lat_pj) begin
      pj_q <= dim_rd_q;
    end
  end

  // Advance split valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.step;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Split pipeline: two multiplies, two clamped adds, running minimum
  always_ff @(posedge clk_i) begin
    first1_q <= ctrl_i.first;
    zb1_q    <= ctrl_i.zero_b;

    m1_q     <= P1W'(pim1_q) * P1W'(dim_rd_q);
    ca2_q    <= first1_q ? '0 : rda_q;
    cb2_q    <= zb1_q ? '0 : rdb_q;
    first2_q <= first1_q;

    prod3_q  <= P2W'(m1_q) * P2W'(pj_q);
    ca3_q    <= ca2_q;
    cb3_q    <= cb2_q;
    first3_q <= first2_q;

    s4_q     <= mcoc_pkg::sat_add(CSW'(prod3_q), ca3_q);
    cb4_q    <= cb3_q;
    first4_q <= first3_q;

    c5_q     <= mcoc_pkg::sat_add(s4_q, cb4_q);
    first5_q <= first4_q;

    if (v5_q && (first5_q || (c5_q < best_q))) begin
      best_q <= c5_q;
    end
  end

  assign stat_o.busy = v1_q | v2_q | v3_q | v4_q | v5_q;
  assign stat_o.best = best_q;

endmodule
